[sv/tcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared types and constants for the three-channel timed ramp.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int CHANNELS = 3;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VAL_W    = 32;
  localparam int DUR_W    = 16;
  localparam int CHF_W    = 2;    // channel field width on the bus
  localparam int OUT_N    = 3;    // value fields in a result beat
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 104;

  localparam logic [VAL_W-1:0] UNITY = VAL_W'(32'h0001_0000);

  // one RAM word per channel
  typedef struct packed {
    logic [VAL_W-1:0] vel;
    logic [VAL_W-1:0] tgt;
    logic [VAL_W-1:0] cur;
  } chan_ent_t;

  localparam int ENT_W = $bits(chan_ent_t);

  localparam chan_ent_t RST_ENT = '{vel: '0, tgt: UNITY, cur: UNITY};

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETRD,
    ST_DIV,
    ST_RD0,
    ST_SWEEP,
    ST_PUSH
  } st_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIX
  } dv_st_t;

endpackage : tcr_pkg
`default_nettype wire

[sv/tcr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcr_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tcr_ram
`default_nettype wire

[sv/tcr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcr_div
// Serial signed divide, one quotient bit per cycle, truncating toward zero.
// The caller must keep the divisor positive; the divider does not enforce it.
// ----------------------------------------------------------------------------
module tcr_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tcr_pkg::VAL_W-1:0]  dividend,
  input  wire logic [tcr_pkg::DUR_W-1:0]  divisor,
  output logic                            done,
  output logic      [tcr_pkg::VAL_W-1:0]  quotient
);
  import tcr_pkg::*;

  localparam int REM_W = DUR_W + 1;
  localparam int CNT_W = $clog2(VAL_W);

  dv_st_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [VAL_W-1:0] dvd_r, dvd_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0] rem_sh;
  logic             qbit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (start) state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == '0) state_nxt = DV_FIX;
      DV_FIX:  state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  assign rem_sh = {rem_r[REM_W-2:0], dvd_r[VAL_W-1]};
  assign qbit   = (rem_sh >= {1'b0, divisor});

  always_comb begin
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    done    = 1'b0;
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          neg_nxt = dividend[VAL_W-1];
          dvd_nxt = dividend[VAL_W-1] ? (~dividend + 1'b1) : dividend;
          rem_nxt = '0;
          quo_nxt = '0;
          cnt_nxt = CNT_W'(VAL_W - 1);
        end
      end
      DV_RUN: begin
        rem_nxt = qbit ? (rem_sh - {1'b0, divisor}) : rem_sh;
        quo_nxt = {quo_r[VAL_W-2:0], qbit};
        dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      DV_FIX: begin
        quo_nxt = neg_r ? (~quo_r + 1'b1) : quo_r;
        done    = 1'b1;
      end
      default: ;
    endcase
  end

  // quotient is valid in the cycle done is high
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

endmodule : tcr_div
`default_nettype wire

[sv/three_channel_timed_ramp_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Flow (accept edge to out_tvalid): a tick passes ST_IDLE, ST_SWEEP over each
//   channel and ST_PUSH; a set to a used channel adds ST_SETRD, then ST_DIV
//   for a ramp (the 32-step serial divider), and ST_RD0 ahead of the sweep.
// Flow control: one beat at a time. The next beat is taken once the
//   previous one has reached the output register, even while it waits there.
// Reset: per-channel valid bits clear, so every channel reads as 1.0 / 1.0 / 0.
// ----------------------------------------------------------------------------
// three_channel_timed_ramp_top
// Per-channel ramp state in a small RAM; read-modify-write sequencer for
// ticks and target sets, with a serial divider for the velocity.
// ----------------------------------------------------------------------------
module three_channel_timed_ramp_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [1:0] channel, [33:2] target_value, [49:34] duration, [55:50] zero
  input  wire logic [tcr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  wire logic                               in_tuser,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [31:0] value_x, [63:32] value_y, [95:64] value_z, [98:96] moving_mask,
  // [103:99] zero
  output logic      [tcr_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import tcr_pkg::*;

  // --------------------------------------------------------------------------
  // Input field unpack
  // --------------------------------------------------------------------------
  logic [CHF_W-1:0] in_ch;
  logic [VAL_W-1:0] in_tgt;
  logic [DUR_W-1:0] in_dur;
  logic             in_acc;

  assign in_ch  = in_tdata[CHF_W-1:0];
  assign in_tgt = in_tdata[CHF_W+VAL_W-1:CHF_W];
  assign in_dur = in_tdata[CHF_W+VAL_W+DUR_W-1:CHF_W+VAL_W];
  assign in_acc = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  st_t              state_r, state_nxt;
  logic [CH_W-1:0]  rd_idx_r, rd_idx_nxt;   // entry whose read data is arriving
  logic             tick_r, tick_nxt;       // sweep modifies entries
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [VAL_W-1:0] tgt_r, tgt_nxt;
  logic [DUR_W-1:0] dur_r, dur_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;         // current value held across divide
  logic [CHANNELS-1:0] vld_r;
  logic             rd_vld_r;
  logic [VAL_W-1:0] col_val_r [OUT_N];
  logic [VAL_W-1:0] col_val_nxt [OUT_N];
  logic [OUT_N-1:0] col_mask_r, col_mask_nxt;
  logic [VAL_W-1:0] out_val_r [OUT_N];
  logic [VAL_W-1:0] out_val_nxt [OUT_N];
  logic [OUT_N-1:0] out_mask_r, out_mask_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  // --------------------------------------------------------------------------
  // RAM and divider
  // --------------------------------------------------------------------------
  logic            ram_we, ram_re;
  logic [CH_W-1:0] ram_waddr, ram_raddr;
  chan_ent_t       ram_wdata, ram_rdata, rd_ent;

  tcr_ram #(
    .WIDTH  (ENT_W),
    .DEPTH  (CHANNELS),
    .ADDR_W (CH_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as the reset state
  assign rd_ent = rd_vld_r ? ram_rdata : RST_ENT;

  logic             div_start, div_done;
  logic [VAL_W-1:0] div_q;

  // difference wraps in 32 bits; sampled on div_start in ST_SETRD
  tcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tgt_r - rd_ent.cur),
    .divisor  (dur_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // --------------------------------------------------------------------------
  // Tick update of the entry being swept
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] s_vel, s_tgt, s_sum;
  logic                    passed;
  chan_ent_t               tick_ent, sweep_ent;

  assign s_vel  = rd_ent.vel;
  assign s_tgt  = rd_ent.tgt;
  assign s_sum  = rd_ent.cur + rd_ent.vel;
  assign passed = (s_vel > 0 && s_sum > s_tgt) || (s_vel < 0 && s_sum < s_tgt);

  always_comb begin
    tick_ent = rd_ent;
    if (rd_ent.vel != '0) begin
      if (passed) begin
        tick_ent.cur = rd_ent.tgt;
        tick_ent.vel = '0;
      end else begin
        tick_ent.cur = s_sum;
      end
    end
  end

  assign sweep_ent = tick_r ? tick_ent : rd_ent;

  logic ch_ok;
  assign ch_ok = (32'(in_ch) < 32'(CHANNELS));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == OP_SET && ch_ok) ? ST_SETRD : ST_SWEEP;
        end
      end
      ST_SETRD: state_nxt = ($signed(dur_r) > 0) ? ST_DIV : ST_RD0;
      ST_DIV:   if (div_done) state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_SWEEP;
      ST_SWEEP: if (rd_idx_r == CH_W'(CHANNELS - 1)) state_nxt = ST_PUSH;
      ST_PUSH:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    ram_we         = 1'b0;
    ram_waddr      = ch_r;
    ram_wdata      = rd_ent;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    div_start      = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    tick_nxt       = tick_r;
    ch_nxt         = ch_r;
    tgt_nxt        = tgt_r;
    dur_nxt        = dur_r;
    cur_nxt        = cur_r;
    col_val_nxt    = col_val_r;
    col_mask_nxt   = col_mask_r;
    out_val_nxt    = out_val_r;
    out_mask_nxt   = out_mask_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_nxt  = CH_W'(in_ch);
          tgt_nxt = in_tgt;
          dur_nxt = in_dur;
          for (int k = 0; k < OUT_N; k++) col_val_nxt[k] = '0;
          col_mask_nxt = '0;
          rd_idx_nxt   = '0;
          ram_re       = 1'b1;
          if (in_tuser == OP_SET && ch_ok) begin
            ram_raddr = CH_W'(in_ch);
            tick_nxt  = 1'b0;
          end else begin
            ram_raddr = '0;
            tick_nxt  = (in_tuser == OP_TICK);
          end
        end
      end
      ST_SETRD: begin
        cur_nxt = rd_ent.cur;
        if ($signed(dur_r) > 0) begin
          div_start = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{vel: '0, tgt: tgt_r, cur: tgt_r};
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_wdata = '{vel: div_q, tgt: tgt_r, cur: cur_r};
        end
      end
      ST_RD0: begin
        ram_re     = 1'b1;
        ram_raddr  = '0;
        rd_idx_nxt = '0;
      end
      ST_SWEEP: begin
        ram_we    = tick_r;
        ram_waddr = rd_idx_r;
        ram_wdata = sweep_ent;
        for (int k = 0; k < OUT_N; k++) begin
          if (k < CHANNELS && rd_idx_r == CH_W'(k)) begin
            col_val_nxt[k]  = sweep_ent.cur;
            col_mask_nxt[k] = (sweep_ent.vel != '0);
          end
        end
        if (rd_idx_r != CH_W'(CHANNELS - 1)) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_r + 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_PUSH: begin
        if (!out_tvalid_r || out_tready) begin
          out_val_nxt    = col_val_r;
          out_mask_nxt   = col_mask_r;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (ram_we) vld_r[ram_waddr] <= 1'b1;
    end
    if (ram_re) rd_vld_r <= vld_r[ram_raddr];
    rd_idx_r   <= rd_idx_nxt;
    tick_r     <= tick_nxt;
    ch_r       <= ch_nxt;
    tgt_r      <= tgt_nxt;
    dur_r      <= dur_nxt;
    cur_r      <= cur_nxt;
    col_val_r  <= col_val_nxt;
    col_mask_r <= col_mask_nxt;
    out_val_r  <= out_val_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_mask_r, out_val_r[2], out_val_r[1], out_val_r[0]};

endmodule : three_channel_timed_ramp_top
`default_nettype wire

[verif/ramp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramp_checker
// Passive monitor for the three-channel timed ramp. It tracks per-channel
// position, goal and rate from accepted input beats, queues the result each
// one should produce, and compares every accepted result beat field by field.
// ----------------------------------------------------------------------------
module ramp_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [tcr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tuser,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [tcr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                                    errors,
  output int                                    waiting
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [2:0]  mask;
  } ramp_values_t;

  logic signed [31:0] pos  [tcr_pkg::CHANNELS];
  logic signed [31:0] goal [tcr_pkg::CHANNELS];
  logic signed [31:0] rate [tcr_pkg::CHANNELS];

  ramp_values_t predicted_values[$];

  function automatic void load_target(int unsigned ch, logic signed [31:0] new_goal,
                                      logic signed [15:0] dur);
    logic [31:0] gap;
    longint      step;
    if (ch >= tcr_pkg::CHANNELS) return;
    if (dur > 0) begin
      gap      = new_goal - pos[ch];
      step     = longint'($signed(gap)) / longint'(dur);
      goal[ch] = new_goal;
      rate[ch] = step[31:0];
    end else begin
      pos[ch]  = new_goal;
      goal[ch] = new_goal;
      rate[ch] = '0;
    end
  endfunction

  function automatic void advance_all();
    logic signed [31:0] nxt;
    for (int i = 0; i < tcr_pkg::CHANNELS; i++) begin
      if (rate[i] != 0) begin
        nxt    = pos[i] + rate[i];
        pos[i] = nxt;
        // overshoot in the direction of motion: park on the goal
        if ((rate[i] > 0 && nxt > goal[i]) || (rate[i] < 0 && nxt < goal[i])) begin
          pos[i]  = goal[i];
          rate[i] = '0;
        end
      end
    end
  endfunction

  function automatic ramp_values_t snapshot();
    ramp_values_t r;
    logic [31:0]  v [3];
    r.mask = '0;
    for (int i = 0; i < 3; i++) begin
      v[i] = '0;
      if (i < tcr_pkg::CHANNELS) begin
        v[i] = pos[i];
        if (rate[i] != 0) r.mask[i] = 1'b1;
      end
    end
    r.x = v[0];
    r.y = v[1];
    r.z = v[2];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ramp_values_t got;
    ramp_values_t want;
    if (!rst_n) begin
      for (int i = 0; i < tcr_pkg::CHANNELS; i++) begin
        pos[i]  = tcr_pkg::UNITY;
        goal[i] = tcr_pkg::UNITY;
        rate[i] = '0;
      end
      predicted_values.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.x    = out_tdata[31:0];
        got.y    = out_tdata[63:32];
        got.z    = out_tdata[95:64];
        got.mask = out_tdata[98:96];
        if (predicted_values.size() == 0) begin
          $error("result beat with nothing predicted: %h", out_tdata);
          errors++;
        end else begin
          want = predicted_values.pop_front();
          check_field("value_x", want.x, got.x);
          check_field("value_y", want.y, got.y);
          check_field("value_z", want.z, got.z);
          check_field("moving_mask", 32'(want.mask), 32'(got.mask));
        end
      end
      if (in_tvalid && in_tready) begin
        if (tcr_pkg::op_t'(in_tuser) == tcr_pkg::OP_SET)
          load_target(in_tdata[1:0], in_tdata[33:2], in_tdata[49:34]);
        else
          advance_all();
        predicted_values.push_back(snapshot());
      end
    end
    waiting = predicted_values.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the three-channel timed ramp. A directed burst
// hits the field extremes and corner cases, then three random phases run
// with different idle profiles on each side; ramp_checker does all result checking.
// ----------------------------------------------------------------------------
module tb;
  import tcr_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int PHASE_BEATS    = 460;
  localparam int RX_HOLD_CYCLES = 300;
  // longest path through the block is a ramp set, which waits on the serial divider
  localparam int DRAIN_CYCLES   = 2 * (CHANNELS + 40);

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [1:0] channel, [33:2] target_value, [49:34] duration, [55:50] zero
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // [0] operation
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [31:0] value_x, [63:32] value_y, [95:64] value_z, [98:96] moving_mask
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int waiting;
  int cycle_count = 0;

  // idle odds in percent for each side, changed per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;

  // what the run actually exercised, for the summary
  int n_tick = 0, n_ramp = 0, n_jump = 0, n_bad_ch = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  three_channel_timed_ramp_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ramp_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (fail_count),
    .waiting    (waiting)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result side: random backpressure, plus one long hold on request. The
  // hold is counted here so the sender keeps offering beats meanwhile and
  // the block backs up into its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Present one beat at a falling edge after a random gap and hold it until
  // the block takes it. Returns right after the accepting rising edge, so
  // the next falling edge is free for either the next beat or a gap.
  task automatic send_beat(input op_t op, input logic [1:0] ch,
                           input logic [31:0] tgt, input logic [15:0] dur);
    @(negedge clk);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, dur, tgt, ch};
    do @(posedge clk); while (!in_tready);
    if (op == OP_TICK)               n_tick++;
    else if (ch >= CHANNELS)         n_bad_ch++;
    else if ($signed(dur) > 0)       n_ramp++;
    else                             n_jump++;
  endtask

  // tick fields are don't-care; fill them with noise
  task automatic send_tick();
    send_beat(OP_TICK, 2'($urandom), $urandom, 16'($urandom));
  endtask

  // stop offering, let every outstanding result come back, then let the
  // pipeline settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (waiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_beat();
    int unsigned pick;
    logic [31:0] tgt;
    logic [15:0] dur;
    logic [1:0]  ch;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_tick();
    end else begin
      // channel: mostly real, sometimes the unused index
      ch = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(CHANNELS - 1));
      pick = $urandom_range(99);
      if (pick < 50)      tgt = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      else if (pick < 80) tgt = $urandom;
      else if (pick < 90) begin
        case ($urandom_range(4))
          0:       tgt = 32'h7FFF_FFFF;
          1:       tgt = 32'h8000_0000;
          2:       tgt = 32'h0000_0000;
          3:       tgt = 32'hFFFF_FFFF;
          default: tgt = UNITY;
        endcase
      end else tgt = 32'($signed($urandom_range(0, 65535)) - 32768);
      // duration: mostly short ramps so they finish, plus jumps and noise
      pick = $urandom_range(99);
      if (pick < 70)      dur = 16'($urandom_range(1, 24));
      else if (pick < 80) dur = 16'd0;
      else if (pick < 90) dur = 16'(-$signed($urandom_range(1, 32768)));
      else                dur = 16'($urandom);
      send_beat(OP_SET, ch, tgt, dur);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed burst, no idling ----
    send_tick();                                          // idle block, junk fields
    send_beat(OP_SET, 2'd0, 32'h7FFF_FFFF, 16'd1);        // huge positive rate
    send_tick();                                          // lands exactly on goal
    send_tick();                                          // wraps, still moving
    send_beat(OP_SET, 2'd1, 32'h8000_0000, 16'h7FFF);     // wrapped gap, longest ramp
    send_beat(OP_SET, 2'd2, 32'hFFFF_FFFF, 16'h8000);     // most negative duration: jump
    send_beat(OP_SET, 2'd2, 32'h0000_0000, 16'd0);        // zero duration: jump
    send_beat(OP_SET, 2'd3, 32'h1234_5678, 16'd5);        // unused channel, no effect
    send_beat(OP_SET, 2'd0, 32'h0000_0000, 16'hFFFF);     // jump to zero
    send_beat(OP_SET, 2'd0, 32'd10, 16'd3);               // rate 3, overshoots, clamps
    send_beat(OP_SET, 2'd1, 32'h0000_0000, 16'd0);
    send_beat(OP_SET, 2'd1, 32'hFFFF_FFF6, 16'd3);        // rate -3, truncated toward zero
    send_beat(OP_SET, 2'd2, 32'h8000_0000, 16'd1);        // most negative rate
    repeat (5) send_tick();
    send_beat(OP_SET, 2'd2, 32'h7FFF_FFFF, 16'h7FFF);
    send_beat(OP_SET, 2'd3, 32'hFFFF_FFFF, 16'h8000);
    send_tick();
    drain();

    // ---- random phases ----
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 31; rx_idle_pct = 75; end
        1:       begin tx_idle_pct = 75; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 0 && n == PHASE_BEATS / 2) drain();   // sender waits out all results
        if (phase == 2 && n == 100) hold_req = 1'b1;       // long output stall, input keeps coming
        random_beat();
      end
      drain();
    end

    $display("covered %0d ticks, %0d ramp sets, %0d jump sets, %0d sets to the unused channel",
             n_tick, n_ramp, n_jump, n_bad_ch);
    $display("across three idle profiles and a %0d-cycle result stall", RX_HOLD_CYCLES);
    if (fail_count == 0 && waiting == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[files.f]
sv/tcr_pkg.sv
sv/tcr_ram.sv
sv/tcr_div.sv
sv/three_channel_timed_ramp_top.sv
verif/ramp_checker.sv
verif/tb.sv
